// File: hw/rtl/sbda_pkg.sv
// shared constants and types for the signed binary to decimal ascii core
`timescale 1ns / 1ps
`default_nettype none
package sbda_pkg;

  localparam int VALUE_WIDTH       = 32;
  localparam int DIGIT_STORE_DEPTH = 10;
  localparam int DIGIT_IDX_W       = $clog2(DIGIT_STORE_DEPTH);
  localparam int BIT_CNT_W         = $clog2(VALUE_WIDTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int           CHAR_W     = 6;
  localparam logic [5:0]   CHAR_ZERO  = 6'd48;
  localparam logic [5:0]   CHAR_MINUS = 6'd45;

  // one classified request: sign and unsigned magnitude
  typedef struct packed {
    logic                   negative;
    logic [VALUE_WIDTH-1:0] magnitude;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/signed_binary_to_decimal_ascii_core.sv
// top level of the signed binary to decimal ascii core
// input channel: one request per signed value_i, taken when in_valid_i is
//   high and in_stall_o is low
// output channel: one ascii character per transfer on ascii_char_o, taken
//   when out_valid_o is high and out_stall_i is low; last_char_o marks the
//   final character of a number
// text: '-' for negative values, then the decimal digits most significant
//   first, no leading zeros, zero prints as "0"; the most negative value
//   prints its full magnitude
// structure: front register for sign and magnitude, a two-entry queue, and
//   a back end doing one shift-and-add-3 step per cycle over all value bits,
//   then one digit position per cycle from the top of the digit store while
//   the output is not stalled
// sequence: per request the back end pops the queue, converts over all
//   value bits, sends a minus sign for a negative value, then walks the
//   digit positions, skipping leading zeros
// stall: the output register holds while out_stall_i is high; the queue and
//   front register keep taking requests until full, then in_stall_o rises
// reset: rst_ni clears all valid flags, the queue and the back end state
`timescale 1ns / 1ps
`default_nettype none
module signed_binary_to_decimal_ascii_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [sbda_pkg::VALUE_WIDTH-1:0]  value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [sbda_pkg::CHAR_W-1:0]            ascii_char_o,
  output logic                                   last_char_o
);

  sbda_pkg::queue_status_t q_status;
  sbda_pkg::item_t         push_item;
  sbda_pkg::item_t         pop_item;
  logic                    push;
  logic                    pop;

  // classify and register the incoming value
  sbda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // decouples acceptance from the slow conversion and emission
  sbda_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  // conversion and character output
  sbda_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .pop_item_i   (pop_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

endmodule
`default_nettype wire

// File: hw/rtl/sbda_front.sv
// front end: accepts a request, splits sign and magnitude, hands it to the queue
`timescale 1ns / 1ps
`default_nettype none
module sbda_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [sbda_pkg::VALUE_WIDTH-1:0]  value_i,
  input  sbda_pkg::queue_status_t                q_status_i,
  output logic                                   push_o,
  output sbda_pkg::item_t                        push_item_o
);

  logic            valid_q, valid_d;
  sbda_pkg::item_t item_q, item_d;
  logic            accept;

  assign push_o      = valid_q && !q_status_i.full;
  assign in_stall_o  = valid_q && q_status_i.full;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_item_o = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d          = 1'b1;
      item_d.negative  = value_i[sbda_pkg::VALUE_WIDTH-1];
      // most negative value wraps to the unsigned 2^(w-1), which is right
      item_d.magnitude = value_i[sbda_pkg::VALUE_WIDTH-1]
                         ? (sbda_pkg::VALUE_WIDTH'(~value_i) + sbda_pkg::VALUE_WIDTH'(1))
                         : value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule
`default_nettype wire

// File: hw/rtl/sbda_queue.sv
// short queue of classified requests between front and back end
`timescale 1ns / 1ps
`default_nettype none
module sbda_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  sbda_pkg::item_t          push_item_i,
  input  wire logic                pop_i,
  output sbda_pkg::item_t          pop_item_o,
  output sbda_pkg::queue_status_t  status_o
);

  sbda_pkg::item_t                   entries_q [sbda_pkg::QUEUE_DEPTH];
  logic [sbda_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [sbda_pkg::QUEUE_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [sbda_pkg::QUEUE_CNT_W-1:0]  count_q, count_d;

  function automatic logic [sbda_pkg::QUEUE_PTR_W-1:0] next_ptr(
    input logic [sbda_pkg::QUEUE_PTR_W-1:0] p
  );
    if (p == sbda_pkg::QUEUE_PTR_W'(sbda_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + sbda_pkg::QUEUE_PTR_W'(1);
  endfunction

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == sbda_pkg::QUEUE_CNT_W'(sbda_pkg::QUEUE_DEPTH));
  assign pop_item_o     = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + sbda_pkg::QUEUE_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - sbda_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sbda_back.sv
// back end: shift-and-add-3 conversion and character emission
`timescale 1ns / 1ps
`default_nettype none
module sbda_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  sbda_pkg::queue_status_t             q_status_i,
  input  sbda_pkg::item_t                     pop_item_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [sbda_pkg::CHAR_W-1:0]         ascii_char_o,
  output logic                                last_char_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam int W = sbda_pkg::VALUE_WIDTH;
  localparam int D = sbda_pkg::DIGIT_STORE_DEPTH;

  logic [1:0]                         state_q, state_d;
  logic [W-1:0]                       mag_q, mag_d;
  logic                               neg_q, neg_d;
  logic [D-1:0][3:0]                  bcd_q, bcd_d;
  logic                               ovf_q, ovf_d;
  logic                               lead_q, lead_d;
  logic [sbda_pkg::BIT_CNT_W-1:0]     cnt_q, cnt_d;
  logic [sbda_pkg::DIGIT_IDX_W-1:0]   idx_q, idx_d;
  logic                               out_valid_q, out_valid_d;
  logic [sbda_pkg::CHAR_W-1:0]        char_q, char_d;
  logic                               last_q, last_d;

  logic [D-1:0][3:0]                  adj;
  logic [4*D-1:0]                     adj_flat;
  logic                               out_free;
  logic [3:0]                         digit;

  // add 3 to every digit of five or more, then shift in the next magnitude bit
  always_comb begin
    for (int i = 0; i < D; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end
  assign adj_flat = adj;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign digit        = bcd_q[idx_q];
  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    bcd_d       = bcd_q;
    ovf_d       = ovf_q;
    lead_d      = lead_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          mag_d   = pop_item_i.magnitude;
          neg_d   = pop_item_i.negative;
          bcd_d   = '0;
          ovf_d   = 1'b0;
          cnt_d   = sbda_pkg::BIT_CNT_W'(W - 1);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_d = {adj_flat[4*D-2:0], mag_q[W-1]};
        mag_d = {mag_q[W-2:0], 1'b0};
        // a bit leaving the top digit means the value no longer fits
        ovf_d = ovf_q | adj_flat[4*D-1];
        if (cnt_q == '0) begin
          idx_d   = sbda_pkg::DIGIT_IDX_W'(D - 1);
          lead_d  = 1'b1;
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end else begin
          cnt_d = cnt_q - sbda_pkg::BIT_CNT_W'(1);
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = sbda_pkg::CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (lead_q && (digit == 4'd0) && (idx_q != '0) && !ovf_q) begin
          // leading zero, skip
          idx_d = idx_q - sbda_pkg::DIGIT_IDX_W'(1);
        end else if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = sbda_pkg::CHAR_ZERO + sbda_pkg::CHAR_W'(digit);
          last_d      = (idx_q == '0);
          lead_d      = 1'b0;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - sbda_pkg::DIGIT_IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    bcd_q  <= bcd_d;
    ovf_q  <= ovf_d;
    lead_q <= lead_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule
`default_nettype wire

// File: hw/rtl/sbda_checker.sv
// port-level checks for the signed binary to decimal ascii core
`timescale 1ns / 1ps
`default_nettype none
module sbda_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic [sbda_pkg::VALUE_WIDTH-1:0]  value_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [sbda_pkg::CHAR_W-1:0]       ascii_char_o,
  input wire logic                              last_char_o
);

  // a stalled request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(value_i))
    else $error("stalled input request changed");

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ascii_char_o)
      && $stable(last_char_o))
    else $error("stalled output character changed");

  // only a minus sign or a decimal digit is ever shown
  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ascii_char_o == sbda_pkg::CHAR_MINUS)
      || ((ascii_char_o >= sbda_pkg::CHAR_ZERO) && (ascii_char_o <= 6'd57)))
    else $error("output character is not a digit or minus");

  // a number never ends on its sign
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ascii_char_o == sbda_pkg::CHAR_MINUS) |-> !last_char_o)
    else $error("minus sign flagged as last character");

  // a taken sign is not followed at once by another sign
  a_minus_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (ascii_char_o == sbda_pkg::CHAR_MINUS)
      |=> !(out_valid_o && (ascii_char_o == sbda_pkg::CHAR_MINUS)))
    else $error("two minus signs in a row");

endmodule

bind signed_binary_to_decimal_ascii_core sbda_checker u_sbda_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .value_i      (value_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .ascii_char_o (ascii_char_o),
  .last_char_o  (last_char_o)
);
`default_nettype wire

// File: sim/tb_top.sv
// self-checking testbench for the signed binary to decimal ascii core
`timescale 1ns / 1ps
module tb_top;
  import sbda_pkg::*;

  localparam int CLK_HALF_NS    = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int N_DIRECTED     = 20;
  localparam int RANDOM_VALUES  = 80;
  localparam int QUIET_VALUES   = 20;
  // idle time after the drain, ample for any stray output to appear
  localparam int DRAIN_CYCLES   = 120;
  localparam int TIMEOUT_NS     = 4_000_000;
  localparam logic [VALUE_WIDTH-1:0] RADIX = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic [VALUE_WIDTH-1:0] value_i     = '0;
  logic                   out_stall_i = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [CHAR_W-1:0]      ascii_char_o;
  logic                   last_char_o;

  // characters still owed by the core, oldest first
  text_char_t expected_text_q[$];
  int         mismatch_count = 0;
  int         chars_checked  = 0;
  int         values_sent    = 0;
  int         negative_sent  = 0;
  bit         quiet_tail     = 1'b0;

  // directed requests: typed text where it is obvious, empty text means
  // the expected characters come from the text predictor
  logic [VALUE_WIDTH-1:0] dir_value [N_DIRECTED] = '{
    32'd0, 32'd1, 32'd9, 32'd10,
    32'hFFFF_FFFF, 32'hFFFF_FFF7, 32'hFFFF_FFF6,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
    32'd1000000000, 32'd999999999, 32'hC465_3600,
    32'd100, 32'd12345, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd4294967, 32'hFFFF_FF9C, 32'd65536
  };
  string dir_text [N_DIRECTED] = '{
    "0", "1", "9", "10",
    "-1", "-9", "-10",
    "2147483647", "-2147483648", "-2147483647",
    "1000000000", "999999999", "-1000000000",
    "", "", "", "", "", "", ""
  };

  signed_binary_to_decimal_ascii_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

  always begin
    #CLK_HALF_NS clk_i = 1'b1;
    #CLK_HALF_NS clk_i = 1'b0;
  end

  // decimal text of one two's complement value: optional minus, then digits
  // most significant first, no leading zeros; the unsigned negate makes the
  // most negative value come out as its full magnitude
  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] v);
    logic                   negative;
    logic [VALUE_WIDTH-1:0] mag;
    logic [3:0]             digit_store [DIGIT_STORE_DEPTH];
    int                     n_digits;
    text_char_t             c;
    negative = v[VALUE_WIDTH-1];
    mag      = negative ? (~v + 1'b1) : v;
    n_digits = 0;
    // digits beyond the store depth are dropped, lowest ones kept
    do begin
      digit_store[n_digits] = 4'(mag % RADIX);
      mag = mag / RADIX;
      n_digits++;
    end while (mag != 0 && n_digits < DIGIT_STORE_DEPTH);
    if (negative) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      expected_text_q.push_back(c);
    end
    while (n_digits > 0) begin
      n_digits--;
      c.code = CHAR_ZERO + CHAR_W'(digit_store[n_digits]);
      c.last = (n_digits == 0);
      expected_text_q.push_back(c);
    end
  endfunction

  // offer one request, wait for the handshake, then record its text and
  // maybe idle the input for a random burst
  task automatic send_value(input logic [VALUE_WIDTH-1:0] v, input string text);
    text_char_t c;
    byte        ch;
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (text.len() == 0) begin
      predict_text(v);
    end else begin
      for (int k = 0; k < text.len(); k++) begin
        ch     = text[k];
        c.code = ch[CHAR_W-1:0];
        c.last = (k == text.len() - 1);
        expected_text_q.push_back(c);
      end
    end
    values_sent++;
    if (v[VALUE_WIDTH-1]) negative_sent++;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // hold off new requests until the core has emitted everything owed
  task automatic drain_text();
    in_valid_i <= 1'b0;
    while (expected_text_q.size() != 0) @(posedge clk_i);
  endtask

  // stimulus: reset, directed table, random values, then drain and report
  initial begin
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] pow10;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) send_value(dir_value[i], dir_text[i]);
    drain_text();

    for (int i = 0; i < RANDOM_VALUES; i++) begin
      if (i == RANDOM_VALUES / 2) drain_text();
      // last stretch runs back to back with no stall on the output
      if (i == RANDOM_VALUES - QUIET_VALUES) quiet_tail = 1'b1;
      case ($urandom_range(0, 5))
        0: v = $urandom();
        1: v = $urandom_range(0, 99);
        2: v = -$urandom_range(1, 99);
        3: begin
          // around a power of ten, either sign
          pow10 = 1;
          repeat ($urandom_range(0, 9)) pow10 = pow10 * RADIX;
          v = pow10 + $urandom_range(0, 2) - 1;
          if ($urandom_range(0, 1)) v = -v;
        end
        4: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                    : 32'h7FFF_FFFF - $urandom_range(0, 3);
        default: begin
          v = $urandom() >> $urandom_range(0, 31);
          if ($urandom_range(0, 1)) v = -v;
        end
      endcase
      send_value(v, "");
    end

    in_valid_i <= 1'b0;
    while (expected_text_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("converted %0d values (%0d directed, %0d negative), %0d characters checked",
             values_sent, N_DIRECTED, negative_sent, chars_checked);
    $display("idle and stall bursts on both channels, two full drains, quiet tail");
    if (mismatch_count == 0 && expected_text_q.size() == 0) begin
      $display("signed_binary_to_decimal_ascii_core: match");
    end else begin
      $display("signed_binary_to_decimal_ascii_core: mismatch");
    end
    $finish;
  end

  // random output stall bursts with free stretches between
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // compare each accepted character against the oldest one owed
  always @(posedge clk_i) begin : check_text
    text_char_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_text_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no character, actual char %0d last %0b",
                 $time, ascii_char_o, last_char_o);
      end else begin
        want = expected_text_q.pop_front();
        chars_checked++;
        if (ascii_char_o !== want.code) begin
          mismatch_count++;
          $display("%0t: ascii_char expected %0d actual %0d",
                   $time, want.code, ascii_char_o);
        end
        if (last_char_o !== want.last) begin
          mismatch_count++;
          $display("%0t: last_char expected %0b actual %0b",
                   $time, want.last, last_char_o);
        end
      end
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d characters still owed", expected_text_q.size());
    $display("signed_binary_to_decimal_ascii_core: mismatch");
    $finish;
  end

endmodule
